// ===== rtl/prafl_pkg.sv =====
package prafl_pkg;

  // Counters saturate at the longest read that is tracked.
  localparam int MAX_READ_LEN = 1024;
  localparam int CNT_W        = $clog2(MAX_READ_LEN + 1);
  localparam int NUM_CLASSES  = 5;
  localparam int CLASS_W      = $clog2(NUM_CLASSES);
  localparam int FRAC_W       = 17;
  localparam int FRAC_SHIFT   = 16;
  localparam int PROD_W       = FRAC_W + CNT_W;
  localparam int DIST_W       = 31;
  localparam int COORD_W      = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [15:0] FLAG_PAIRED   = 16'h0001;
  localparam logic [15:0] FLAG_UNMAPPED = 16'h0004;
  localparam logic [15:0] FLAG_MATE_UNM = 16'h0008;
  localparam logic [15:0] FLAG_DUP      = 16'h0400;
  localparam logic [15:0] FLAG_SUPPL    = 16'h0800;

  localparam logic [3:0] CODE_A = 4'd1;
  localparam logic [3:0] CODE_C = 4'd2;
  localparam logic [3:0] CODE_G = 4'd4;
  localparam logic [3:0] CODE_T = 4'd8;

  localparam logic [CLASS_W-1:0] CLASS_A     = CLASS_W'(0);
  localparam logic [CLASS_W-1:0] CLASS_C     = CLASS_W'(1);
  localparam logic [CLASS_W-1:0] CLASS_G     = CLASS_W'(2);
  localparam logic [CLASS_W-1:0] CLASS_T     = CLASS_W'(3);
  localparam logic [CLASS_W-1:0] CLASS_OTHER = CLASS_W'(4);

  localparam logic [2:0] TYPE_OTHER_CHROM = 3'b001;
  localparam logic [2:0] TYPE_DISTANCE    = 3'b010;
  localparam logic [2:0] TYPE_SUPPL       = 3'b100;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAP_QUALITY   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAIR_DISTANCE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BASE_FRACTION = CFG_IDX_W'(2);

  localparam logic [7:0]        MIN_MAP_QUALITY_RST   = 8'd0;
  localparam logic [DIST_W-1:0] MAX_PAIR_DISTANCE_RST = DIST_W'(10000);
  localparam logic [FRAC_W-1:0] MAX_BASE_FRACTION_RST = FRAC_W'(45875);

  typedef struct packed {
    logic [3:0]                base_code;
    logic                      base_valid;
    logic [15:0]               read_flags;
    logic [7:0]                map_quality;
    logic signed [COORD_W-1:0] ref_id;
    logic signed [COORD_W-1:0] mate_ref_id;
    logic signed [COORD_W-1:0] position;
    logic signed [COORD_W-1:0] mate_position;
    logic                      read_last;
    logic                      fragment_last;
  } in_word_t;

  typedef struct packed {
    logic       read_pass;
    logic [2:0] read_type;
    logic       fragment_done;
    logic       fragment_keep;
    logic [2:0] fragment_type;
  } out_word_t;

  function automatic logic [CLASS_W-1:0] class_of(input logic [3:0] code);
    logic [CLASS_W-1:0] cls;
    unique case (code)
      CODE_A:  cls = CLASS_A;
      CODE_C:  cls = CLASS_C;
      CODE_G:  cls = CLASS_G;
      CODE_T:  cls = CLASS_T;
      default: cls = CLASS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

// ===== rtl/prafl_if.sv =====
interface prafl_in_if;
  logic                valid;
  logic                ready;
  prafl_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prafl_out_if;
  logic                 valid;
  logic                 ready;
  prafl_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prafl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [prafl_pkg::CFG_IDX_W-1:0]     index;
  logic [prafl_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/paired_read_abnormality_filter.sv =====
// Paired-read abnormality filter.
// in_ch takes one base per word with the read's flags, quality, reference
// ids and positions; those fields are used on the word with read_last set.
// Each read_last word yields one word on out_ch with the read's verdict and
// type and, with fragment_last, the fragment's keep decision. Other words
// yield nothing. cfg writes the three limits; it is always ready. The user must
// write cfg only while no read is in flight; the block does not enforce it.
// An accepted word passes one input register, then the counters, the
// fraction check (one 17x11 multiply and five compares) and the pair
// checks, which land in the output register.
// One word is taken every cycle unless out_ch stalls a read_last word: it
// waits in the input register and in_ch.ready drops until the result is
// taken; words without read_last keep flowing into the counters.
// Synchronous reset empties both registers, clears the base counters and
// fragment state, and loads the default limits.
module paired_read_abnormality_filter (
  input logic         clk,
  input logic         rst,
  prafl_in_if.sink    in_ch,
  prafl_out_if.source out_ch,
  prafl_cfg_if.sink   cfg
);
  import prafl_pkg::*;

  logic              s1_valid;
  in_word_t          s1_word;
  logic              out_valid;
  out_word_t         out_word;
  logic              out_free;
  logic              s1_move;
  logic              emit;

  logic [7:0]        min_map_quality;
  logic [DIST_W-1:0] max_pair_distance;
  logic [FRAC_W-1:0] max_base_fraction;

  logic              fragment_failed;
  logic [2:0]        fragment_type_acc;
  logic              fragment_failed_next;
  logic [2:0]        fragment_type_next;

  logic              overfrequent;
  logic              read_pass;
  logic [2:0]        read_type;
  logic [COORD_W:0]  diff_fwd;
  logic [COORD_W:0]  diff_rev;
  logic [COORD_W:0]  dist_limit;
  logic              too_far;

  prafl_base_stats u_stats (
    .clk               (clk),
    .rst               (rst),
    .step              (s1_move),
    .clear             (s1_word.read_last),
    .base_valid        (s1_word.base_valid),
    .base_code         (s1_word.base_code),
    .max_base_fraction (max_base_fraction),
    .overfrequent      (overfrequent)
  );

  assign cfg.ready    = 1'b1;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_word;

  always_comb begin
    out_free    = !out_valid || out_ch.ready;
    s1_move     = s1_valid && (!s1_word.read_last || out_free);
    emit        = s1_move && s1_word.read_last;
    in_ch.ready = !s1_valid || s1_move;
  end

  // Both differences are 33 bits wide, so |d| > limit never wraps.
  always_comb begin
    diff_fwd   = {s1_word.position[COORD_W-1], s1_word.position}
               - {s1_word.mate_position[COORD_W-1], s1_word.mate_position};
    diff_rev   = {s1_word.mate_position[COORD_W-1], s1_word.mate_position}
               - {s1_word.position[COORD_W-1], s1_word.position};
    dist_limit = (COORD_W + 1)'(max_pair_distance);
    too_far    = ($signed(diff_fwd) > $signed(dist_limit))
              || ($signed(diff_rev) > $signed(dist_limit));

    read_pass = ((s1_word.read_flags & FLAG_PAIRED) != '0)
             && ((s1_word.read_flags & FLAG_UNMAPPED) == '0)
             && ((s1_word.read_flags & FLAG_MATE_UNM) == '0)
             && ((s1_word.read_flags & FLAG_DUP) == '0)
             && (s1_word.map_quality >= min_map_quality)
             && !overfrequent;

    read_type = '0;
    if (read_pass) begin
      if (s1_word.ref_id != s1_word.mate_ref_id) begin
        read_type = read_type | TYPE_OTHER_CHROM;
      end else if (too_far) begin
        read_type = read_type | TYPE_DISTANCE;
      end
      if ((s1_word.read_flags & FLAG_SUPPL) != '0) begin
        read_type = read_type | TYPE_SUPPL;
      end
    end

    fragment_failed_next = fragment_failed || !read_pass;
    fragment_type_next   = fragment_type_acc | read_type;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_word <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
    if (emit) begin
      out_word.read_pass     <= read_pass;
      out_word.read_type     <= read_type;
      out_word.fragment_done <= s1_word.fragment_last;
      out_word.fragment_keep <= s1_word.fragment_last && !fragment_failed_next
                                && (fragment_type_next != '0);
      out_word.fragment_type <= fragment_type_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_failed   <= 1'b0;
      fragment_type_acc <= '0;
    end else if (emit) begin
      if (s1_word.fragment_last) begin
        fragment_failed   <= 1'b0;
        fragment_type_acc <= '0;
      end else begin
        fragment_failed   <= fragment_failed_next;
        fragment_type_acc <= fragment_type_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_map_quality   <= MIN_MAP_QUALITY_RST;
      max_pair_distance <= MAX_PAIR_DISTANCE_RST;
      max_base_fraction <= MAX_BASE_FRACTION_RST;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_MIN_MAP_QUALITY) begin
        min_map_quality <= cfg.data[7:0];
      end
      if (cfg.index == CFG_MAX_PAIR_DISTANCE) begin
        max_pair_distance <= cfg.data[DIST_W-1:0];
      end
      if (cfg.index == CFG_MAX_BASE_FRACTION) begin
        max_base_fraction <= cfg.data[FRAC_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/prafl_base_stats.sv =====
module prafl_base_stats (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           clear,
  input  logic                           base_valid,
  input  logic [3:0]                     base_code,
  input  logic [prafl_pkg::FRAC_W-1:0]   max_base_fraction,
  output logic                           overfrequent
);
  import prafl_pkg::*;

  logic [CNT_W-1:0]   counts [NUM_CLASSES];
  logic [CNT_W-1:0]   counts_next [NUM_CLASSES];
  logic [CNT_W-1:0]   length;
  logic [CNT_W-1:0]   length_next;
  logic [CLASS_W-1:0] cls;
  logic [PROD_W-1:0]  limit;
  logic [NUM_CLASSES-1:0] over;

  // The check sees the counts including the word that is being taken in.
  always_comb begin
    cls = class_of(base_code);
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (base_valid && cls == CLASS_W'(i) && counts[i] < CNT_W'(MAX_READ_LEN)) begin
        counts_next[i] = counts[i] + CNT_W'(1);
      end else begin
        counts_next[i] = counts[i];
      end
    end
    if (base_valid && length < CNT_W'(MAX_READ_LEN)) begin
      length_next = length + CNT_W'(1);
    end else begin
      length_next = length;
    end
    limit = PROD_W'(max_base_fraction) * PROD_W'(length_next);
    for (int i = 0; i < NUM_CLASSES; i++) begin
      over[i] = PROD_W'({counts_next[i], FRAC_SHIFT'(0)}) > limit;
    end
    overfrequent = |over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        counts[i] <= '0;
      end
      length <= '0;
    end else if (step) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        counts[i] <= clear ? '0 : counts_next[i];
      end
      length <= clear ? '0 : length_next;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import prafl_pkg::*;

  localparam int RANDOM_WORDS   = 1600;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int MAX_REPORTS    = 10;

  logic clk;
  logic rst;

  prafl_in_if  in_ch ();
  prafl_out_if out_ch ();
  prafl_cfg_if cfg_ch ();

  paired_read_abnormality_filter DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // Shadow of the block: limits, per-read base counters and fragment state.
  logic [7:0]        lim_quality;
  logic [DIST_W-1:0] lim_distance;
  logic [FRAC_W-1:0] lim_fraction;
  logic [CNT_W-1:0]  class_cnt [NUM_CLASSES];
  logic [CNT_W-1:0]  read_len;
  logic              frag_failed;
  logic [2:0]        frag_type;
  out_word_t         verdict_q [$];

  int   src_idle_pct = 7;
  int   rcv_idle_pct = 55;
  int   fail_count   = 0;
  int   words_sent   = 0;
  logic rcv_hold;
  event hold_trigger;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic string verdict_text(input out_word_t v);
    return $sformatf("pass=%0b type=%0d done=%0b keep=%0b ftype=%0d", v.read_pass,
                     v.read_type, v.fragment_done, v.fragment_keep, v.fragment_type);
  endfunction

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Updates the shadow state with one accepted word and queues the verdict
  // that a read_last word produces.
  function automatic void predict_word(input in_word_t w);
    logic [CLASS_W-1:0] cls;
    logic               pass;
    logic               crowded;
    logic [2:0]         rtype;
    longint             gap;
    longint             share;
    out_word_t          v;
    if (w.base_valid) begin
      case (w.base_code)
        CODE_A:  cls = CLASS_A;
        CODE_C:  cls = CLASS_C;
        CODE_G:  cls = CLASS_G;
        CODE_T:  cls = CLASS_T;
        default: cls = CLASS_OTHER;
      endcase
      if (class_cnt[cls] < MAX_READ_LEN) class_cnt[cls] = class_cnt[cls] + 1'b1;
      if (read_len < MAX_READ_LEN) read_len = read_len + 1'b1;
    end
    if (!w.read_last) return;

    share = longint'(lim_fraction) * longint'(read_len);
    crowded = 1'b0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (longint'(class_cnt[i]) * 64'sd65536 > share) crowded = 1'b1;
    end
    pass = (w.read_flags & FLAG_PAIRED) != 16'h0 &&
           (w.read_flags & (FLAG_UNMAPPED | FLAG_MATE_UNM | FLAG_DUP)) == 16'h0 &&
           w.map_quality >= lim_quality && !crowded;

    rtype = 3'b000;
    if (pass) begin
      if (w.ref_id != w.mate_ref_id) begin
        rtype = rtype | TYPE_OTHER_CHROM;
      end else begin
        // Full-width difference, so the extremes cannot wrap.
        gap = longint'(w.position) - longint'(w.mate_position);
        if (gap < 0) gap = -gap;
        if (gap > longint'(lim_distance)) rtype = rtype | TYPE_DISTANCE;
      end
      if ((w.read_flags & FLAG_SUPPL) != 16'h0) rtype = rtype | TYPE_SUPPL;
      frag_type = frag_type | rtype;
    end else begin
      frag_failed = 1'b1;
    end

    v.read_pass     = pass;
    v.read_type     = rtype;
    v.fragment_done = w.fragment_last;
    v.fragment_keep = w.fragment_last && !frag_failed && frag_type != 3'b000;
    v.fragment_type = frag_type;
    verdict_q.push_back(v);

    foreach (class_cnt[i]) class_cnt[i] = '0;
    read_len = '0;
    if (w.fragment_last) begin
      frag_failed = 1'b0;
      frag_type   = 3'b000;
    end
  endfunction

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (verdict_q.size() == 0) begin
      log_failure($sformatf("unexpected result: got %s", verdict_text(got)));
      return;
    end
    want = verdict_q.pop_front();
    if (got.read_pass !== want.read_pass || got.read_type !== want.read_type ||
        got.fragment_done !== want.fragment_done ||
        got.fragment_keep !== want.fragment_keep ||
        got.fragment_type !== want.fragment_type) begin
      log_failure($sformatf("result mismatch: expected %s, got %s", verdict_text(want),
                            verdict_text(got)));
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(w);
    @(negedge clk);
  endtask

  // Drops the input, waits until every queued verdict has come back, then
  // lets anything still inside the pipeline settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Leaves valid high so that back-to-back writes need no second assignment.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_MIN_MAP_QUALITY:   lim_quality  = val[7:0];
      CFG_MAX_PAIR_DISTANCE: lim_distance = val[DIST_W-1:0];
      CFG_MAX_BASE_FRACTION: lim_fraction = val[FRAC_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_limits(input logic [7:0] qual, input logic [DIST_W-1:0] distance,
                            input logic [FRAC_W-1:0] frac);
    wait_idle();
    write_reg(CFG_MIN_MAP_QUALITY, CFG_DATA_W'(qual));
    write_reg(CFG_MAX_PAIR_DISTANCE, CFG_DATA_W'(distance));
    write_reg(CFG_MAX_BASE_FRACTION, CFG_DATA_W'(frac));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic in_word_t random_word();
    logic [159:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return noise[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t make_tail(input logic [15:0] flags, input logic [7:0] qual,
                                         input logic signed [31:0] tid, mtid, pos, mpos,
                                         input logic frag_last);
    in_word_t w;
    w = random_word();
    w.read_flags    = flags;
    w.map_quality   = qual;
    w.ref_id        = tid;
    w.mate_ref_id   = mtid;
    w.position      = pos;
    w.mate_position = mpos;
    w.read_last     = 1'b1;
    w.fragment_last = frag_last;
    return w;
  endfunction

  // Last word of a read with mostly sane flags and quality, and a mate
  // position that often sits near the distance limit.
  function automatic in_word_t random_tail(input logic frag_last);
    in_word_t          w;
    logic signed [31:0] tid;
    logic signed [31:0] mtid;
    longint            pos;
    longint            mpos;
    longint            gap;
    longint            span;
    w = random_word();
    w.read_last     = 1'b1;
    w.fragment_last = frag_last;
    if ($urandom_range(99) < 85) begin
      w.read_flags = (w.read_flags | FLAG_PAIRED) &
                     ~(FLAG_UNMAPPED | FLAG_MATE_UNM | FLAG_DUP);
    end
    if ($urandom_range(99) < 85) w.map_quality = 8'($urandom_range(255, lim_quality));

    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        tid  = $urandom_range(3);
        mtid = tid;
      end
      6: begin
        tid  = $urandom_range(3);
        mtid = $urandom_range(3);
      end
      7: begin
        tid  = -1;
        mtid = $urandom_range(1) ? -1 : $urandom_range(3);
      end
      8: begin
        tid  = $urandom_range(32'h7FFF_FFFF);
        mtid = $urandom_range(1) ? tid : $urandom_range(32'h7FFF_FFFF);
      end
      default: begin
        tid  = 32'sh7FFF_FFFF;
        mtid = tid;
      end
    endcase
    w.ref_id      = tid;
    w.mate_ref_id = mtid;

    case ($urandom_range(9))
      0:       pos = -1;
      1:       pos = 64'sd2147483647;
      default: pos = longint'($urandom_range(32'h7FFF_FFFF));
    endcase
    span = longint'(lim_distance);
    case ($urandom_range(3))
      0:       gap = span;
      1:       gap = span + 1;
      default: gap = longint'($urandom_range(32'(span + span / 4 + 2)));
    endcase
    mpos = $urandom_range(1) ? pos + gap : pos - gap;
    if (mpos > 64'sd2147483647) mpos = 64'sd2147483647;
    if (mpos < -1) mpos = -1;
    if ($urandom_range(9) == 0) mpos = longint'($urandom_range(32'h7FFF_FFFF));
    w.position      = pos[31:0];
    w.mate_position = mpos[31:0];
    return w;
  endfunction

  // A read of n_bases words, the last being tail; an empty read is one word
  // without a base. Words without a base may be slipped in between.
  task automatic send_read(input in_word_t tail, input int n_bases, input logic [3:0] bias,
                           input int bias_pct, input int noise_pct);
    in_word_t w;
    if (n_bases == 0) begin
      w = tail;
      w.base_valid = 1'b0;
      send_word(w);
      words_sent++;
      return;
    end
    for (int k = 0; k < n_bases; k++) begin
      if ($urandom_range(99) < noise_pct) begin
        w = random_word();
        w.base_valid = 1'b0;
        w.read_last  = 1'b0;
        send_word(w);
      end
      w = (k == n_bases - 1) ? tail : random_word();
      w.read_last  = (k == n_bases - 1);
      w.base_valid = 1'b1;
      if ($urandom_range(99) < bias_pct) begin
        w.base_code = bias;
      end else begin
        case ($urandom_range(4))
          0:       w.base_code = CODE_A;
          1:       w.base_code = CODE_C;
          2:       w.base_code = CODE_G;
          3:       w.base_code = CODE_T;
          default: w.base_code = 4'($urandom);
        endcase
      end
      send_word(w);
      words_sent++;
    end
  endtask

  task automatic send_random_fragment(input int noise_pct);
    int         n_reads;
    int         len;
    int         bias_pct;
    logic [3:0] bias;
    n_reads = $urandom_range(3, 1);
    for (int r = 0; r < n_reads; r++) begin
      case ($urandom_range(19))
        0:       len = 0;
        1:       len = $urandom_range(40, 13);
        default: len = $urandom_range(12, 1);
      endcase
      case ($urandom_range(3))
        0:       bias = CODE_A;
        1:       bias = CODE_C;
        2:       bias = CODE_G;
        default: bias = CODE_T;
      endcase
      case ($urandom_range(5))
        0:       bias_pct = 40;
        1:       bias_pct = 70;
        2:       bias_pct = 100;
        default: bias_pct = 0;
      endcase
      send_read(random_tail(r == n_reads - 1), len, bias, bias_pct, noise_pct);
    end
  endtask

  task automatic test_reset_limits();
    // Empty read, mate on another chromosome: kept on its own.
    send_read(make_tail(FLAG_PAIRED, 8'd0, 0, 1, 100, 100, 1'b1), 0, CODE_A, 0, 0);
    // Distance exactly at the limit, then just over it, in one fragment.
    send_read(make_tail(FLAG_PAIRED | FLAG_SUPPL, 8'd7, 3, 3, 20000, 10000, 1'b0), 0,
              CODE_A, 0, 0);
    send_read(make_tail(FLAG_PAIRED, 8'd255, 3, 3, 0, 10001, 1'b1), 0, CODE_A, 0, 0);
    // A failed read drops the fragment, though the passing one still adds its type.
    send_read(make_tail(FLAG_PAIRED | FLAG_UNMAPPED, 8'd9, 0, 0, 5, 5, 1'b0), 1,
              CODE_A, 100, 0);
    send_read(make_tail(FLAG_PAIRED, 8'd9, 2, 5, 5, 5, 1'b1), 0, CODE_A, 0, 0);
    send_read(make_tail(FLAG_PAIRED, 8'd50, 1, 1, 500, 400, 1'b1), 3, CODE_G, 100, 0);
    send_read(make_tail(16'h0000, 8'd50, 0, 1, 0, 0, 1'b1), 1, CODE_T, 100, 0);
    send_read(make_tail(FLAG_PAIRED | FLAG_MATE_UNM, 8'd50, 0, 1, 0, 0, 1'b1), 1,
              CODE_T, 100, 0);
    send_read(make_tail(FLAG_PAIRED | FLAG_DUP, 8'd50, 0, 1, 0, 0, 1'b1), 1,
              CODE_T, 100, 0);
  endtask

  task automatic test_limit_extremes();
    set_limits(8'd255, '0, '0);
    send_read(make_tail(FLAG_PAIRED, 8'd254, 0, 1, 0, 0, 1'b1), 0, CODE_A, 0, 0);
    send_read(make_tail(FLAG_PAIRED, 8'd255, -1, -1, 5, 4, 1'b1), 0, CODE_A, 0, 0);
    send_read(make_tail(FLAG_PAIRED, 8'd255, -1, -1, -1, 32'sh7FFF_FFFF, 1'b1), 0,
              CODE_A, 0, 0);
    // With a zero fraction limit any counted base fails the read.
    send_read(make_tail(FLAG_PAIRED, 8'd255, 0, 1, 0, 0, 1'b1), 1, CODE_A, 100, 0);

    set_limits(8'd0, 31'h7FFF_FFFF, 17'd65536);
    send_read(make_tail(16'hFFFF & ~(FLAG_UNMAPPED | FLAG_MATE_UNM | FLAG_DUP), 8'd0,
                        -1, -1, 32'sh7FFF_FFFF, -1, 1'b1), 1, CODE_A, 100, 0);
    send_read(make_tail(FLAG_PAIRED, 8'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        32'sh7FFF_FFFF, 0, 1'b1), 1, CODE_C, 100, 0);

    set_limits(8'd0, '0, 17'd1);
    send_read(make_tail(FLAG_PAIRED, 8'd0, 0, 1, 0, 0, 1'b1), 2, CODE_A, 0, 0);
  endtask

  // Reads past the counter range; the fraction test then uses saturated counts.
  task automatic test_long_reads();
    set_limits(8'd0, 31'd10000, 17'd65000);
    send_read(make_tail(FLAG_PAIRED, 8'd30, 0, 1, 0, 0, 1'b1), 1100, CODE_A, 99, 5);
    set_limits(8'd0, 31'd10000, 17'd13500);
    send_read(make_tail(FLAG_PAIRED, 8'd30, 0, 1, 0, 0, 1'b1), 1030, CODE_A, 0, 0);
  endtask

  task automatic test_backpressure();
    set_limits(8'd20, 31'd5000, 17'd50000);
    src_idle_pct = 0;
    rcv_idle_pct = 0;
    -> hold_trigger;
    repeat (12) send_random_fragment(0);
  endtask

  task automatic test_random_traffic();
    int target;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_limits(8'd255, '0, 17'd65536);
        2: set_limits(8'd0, 31'h7FFF_FFFF, 17'd65535);
        default: set_limits(8'($urandom_range(200)),
                            $urandom_range(1) ? 31'($urandom_range(20000)) : 31'($urandom),
                            17'($urandom_range(65536, 30000)));
      endcase
      case (ph / 2)
        0: begin
          src_idle_pct = 7;
          rcv_idle_pct = 55;
        end
        1: begin
          src_idle_pct = 55;
          rcv_idle_pct = 7;
        end
        default: begin
          src_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      target = words_sent + RANDOM_WORDS / 6;
      while (words_sent < target) send_random_fragment($urandom_range(1) ? 0 : 10);
    end
  endtask

  initial begin : stimulus
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    lim_quality  = 8'd0;
    lim_distance = 31'd10000;
    lim_fraction = 17'd45875;
    foreach (class_cnt[i]) class_cnt[i] = '0;
    read_len     = '0;
    frag_failed  = 1'b0;
    frag_type    = 3'b000;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_reset_limits();
    test_limit_extremes();
    test_long_reads();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    if (fail_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  // Takes results at the rising edge and picks the next ready at the falling one.
  initial begin : result_sink
    logic take;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) check_result(out_ch.data);
      take = !rcv_hold && ($urandom_range(99) >= rcv_idle_pct);
      @(negedge clk);
      out_ch.ready <= take;
    end
  end

  initial begin : stall_timer
    rcv_hold = 1'b0;
    forever begin
      @(hold_trigger);
      rcv_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      @(negedge clk);
      rcv_hold = 1'b0;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/prafl_pkg.sv
rtl/prafl_if.sv
rtl/prafl_base_stats.sv
rtl/paired_read_abnormality_filter.sv
tb/tb_top.sv
